// ===== design/ttq_pkg.sv =====
// Shared types and codes for the timed task queue.
package ttq_pkg;

  localparam int unsigned SLOTS_DEF = 8;

  // operation codes
  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_POP      = 2'd2;

  // result status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_POPPED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [3:0] REL_MAX = 4'd15;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] delay;
    logic [15:0] task_handle;
    logic [31:0] data_handle;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_task;
    logic [31:0] out_data;
    logic [3:0]  released;
  } out_t;

  // write enables of the slot store
  typedef struct packed {
    logic payload;
    logic due;
    logic link;
  } mem_we_t;

endpackage

// ===== design/ttq_slot_mem.sv =====
// Slot store: due tick, handles and list links, one registered read port.
module ttq_slot_mem #(
  parameter int unsigned SLOTS = ttq_pkg::SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [$clog2(SLOTS)-1:0]   rd_addr_i,
  output logic [15:0]                rd_due_o,
  output logic [15:0]                rd_task_o,
  output logic [31:0]                rd_data_o,
  output logic [$clog2(SLOTS+1)-1:0] rd_link_o,
  input  ttq_pkg::mem_we_t           we_i,
  input  logic [$clog2(SLOTS)-1:0]   wr_addr_i,
  input  logic [15:0]                wr_due_i,
  input  logic [15:0]                wr_task_i,
  input  logic [31:0]                wr_data_i,
  input  logic [$clog2(SLOTS+1)-1:0] wr_link_i
);

  localparam int unsigned PW = $clog2(SLOTS+1);

  logic [15:0]   due_mem  [SLOTS];
  logic [15:0]   task_mem [SLOTS];
  logic [31:0]   data_mem [SLOTS];
  logic [PW-1:0] link_mem [SLOTS];

  logic [SLOTS-1:0] link_vld_q;
  logic [PW-1:0]    link_raw_q;
  logic [PW-1:0]    link_dflt_q;
  logic             link_hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i.payload) begin
      task_mem[wr_addr_i] <= wr_task_i;
      data_mem[wr_addr_i] <= wr_data_i;
    end
    if (we_i.due) begin
      due_mem[wr_addr_i] <= wr_due_i;
    end
    if (we_i.link) begin
      link_mem[wr_addr_i] <= wr_link_i;
    end
    rd_due_o    <= due_mem[rd_addr_i];
    rd_task_o   <= task_mem[rd_addr_i];
    rd_data_o   <= data_mem[rd_addr_i];
    link_raw_q  <= link_mem[rd_addr_i];
    link_dflt_q <= PW'(rd_addr_i) + PW'(1);
  end

  // an unwritten link reads as the reset chain: slot i points at i+1, last at null
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      link_hit_q <= 1'b0;
    end else begin
      if (we_i.link) begin
        link_vld_q[wr_addr_i] <= 1'b1;
      end
      link_hit_q <= link_vld_q[rd_addr_i];
    end
  end

  assign rd_link_o = link_hit_q ? link_raw_q : link_dflt_q;

endmodule

// ===== design/timed_task_queue_top.sv =====
// Timed task queue: slot pool with free list, sorted waiting list and ready FIFO.
//
//  channel | signals                              | direction
//  in      | in_valid_i, in_stall_o, in_data_i    | item into block
//  out     | out_valid_o, out_stall_i, out_data_o | one result per item
//
// One item at a time; the lists live in a slot store with one read and one write port.
// A pop takes the ready FIFO head. A schedule with delay 0 appends to the ready FIFO;
// with delay > 0 it walks the waiting list entry by entry. A tick releases due entries
// one by one. The result is shown in the same cycle the next item can first be taken.
// Reset leaves the pool ready at once: unwritten links read as the initial free chain.
// A stalled output holds one result; the next item is still taken meanwhile.
module timed_task_queue_top #(
  parameter int unsigned SLOTS = ttq_pkg::SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ttq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ttq_pkg::out_t out_data_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned PW = $clog2(SLOTS+1);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCHED_LINK, S_WALK_RD, S_WALK_CMP, S_INS_SELF, S_INS_PREV,
    S_TICK_RD, S_TICK_CMP, S_APP_SELF, S_APP_TAIL, S_POP_RD, S_DONE
  } state_e;

  state_e        state_q;
  logic [1:0]    op_q;
  logic [15:0]   delay_q;
  logic [15:0]   now_q;
  logic [PW-1:0] free_first_q, wait_first_q, ready_first_q, ready_last_q;
  logic [PW-1:0] n_q, cur_q, prev_q, cnt_q;
  ttq_pkg::out_t res_q, out_q;
  logic          out_valid_q;

  logic [IW-1:0]    rd_addr, wr_addr;
  logic [15:0]      rd_due, rd_task;
  logic [31:0]      rd_data;
  logic [PW-1:0]    rd_link, wr_link;
  ttq_pkg::mem_we_t we;
  logic [15:0]      due_diff;
  logic [PW+3:0]    cnt_ext;
  logic [3:0]       rel_sat;
  logic             take;

  assign in_stall_o  = (state_q != S_IDLE);
  assign take        = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign due_diff    = rd_due - now_q;
  assign cnt_ext     = (PW+4)'(cnt_q);
  assign rel_sat     = (cnt_ext > (PW+4)'(ttq_pkg::REL_MAX)) ? ttq_pkg::REL_MAX : cnt_ext[3:0];

  ttq_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_due_o  (rd_due),
    .rd_task_o (rd_task),
    .rd_data_o (rd_data),
    .rd_link_o (rd_link),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_due_i  (now_q + delay_q),
    .wr_task_i (in_data_i.task_handle),
    .wr_data_i (in_data_i.data_handle),
    .wr_link_i (wr_link)
  );

  // store port control
  always_comb begin
    rd_addr = '0;
    wr_addr = '0;
    wr_link = NIL;
    we      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (take && in_data_i.operation == ttq_pkg::OP_SCHEDULE) begin
          rd_addr    = free_first_q[IW-1:0];
          wr_addr    = free_first_q[IW-1:0];
          we.payload = (free_first_q != NIL);
        end else if (take && in_data_i.operation == ttq_pkg::OP_POP) begin
          rd_addr = ready_first_q[IW-1:0];
        end
      end
      S_WALK_RD: rd_addr = cur_q[IW-1:0];
      S_TICK_RD: rd_addr = wait_first_q[IW-1:0];
      S_INS_SELF: begin
        we.due  = 1'b1;
        we.link = 1'b1;
        wr_addr = n_q[IW-1:0];
        wr_link = cur_q;
      end
      S_INS_PREV: begin
        we.link = 1'b1;
        wr_addr = prev_q[IW-1:0];
        wr_link = n_q;
      end
      S_APP_SELF: begin
        we.link = 1'b1;
        wr_addr = n_q[IW-1:0];
        wr_link = NIL;
      end
      S_APP_TAIL: begin
        we.link = 1'b1;
        wr_addr = ready_last_q[IW-1:0];
        wr_link = n_q;
      end
      S_POP_RD: begin
        we.link = 1'b1;
        wr_addr = n_q[IW-1:0];
        wr_link = free_first_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= ttq_pkg::OP_SCHEDULE;
      delay_q       <= '0;
      now_q         <= '0;
      free_first_q  <= '0;
      wait_first_q  <= NIL;
      ready_first_q <= NIL;
      ready_last_q  <= NIL;
      n_q           <= NIL;
      cur_q         <= NIL;
      prev_q        <= NIL;
      cnt_q         <= '0;
      res_q         <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded instead
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            op_q    <= in_data_i.operation;
            delay_q <= in_data_i.delay;
            case (in_data_i.operation)
              ttq_pkg::OP_SCHEDULE: begin
                if (free_first_q == NIL) begin
                  res_q   <= {ttq_pkg::ST_FULL, 16'd0, 32'd0, 4'd0};
                  state_q <= S_DONE;
                end else begin
                  res_q   <= '0;
                  n_q     <= free_first_q;
                  state_q <= S_SCHED_LINK;
                end
              end
              ttq_pkg::OP_TICK: begin
                res_q   <= '0;
                now_q   <= now_q + 16'd1;
                cnt_q   <= '0;
                state_q <= S_TICK_RD;
              end
              ttq_pkg::OP_POP: begin
                if (ready_first_q == NIL) begin
                  res_q   <= {ttq_pkg::ST_EMPTY, 16'd0, 32'd0, 4'd0};
                  state_q <= S_DONE;
                end else begin
                  res_q   <= '0;
                  n_q     <= ready_first_q;
                  state_q <= S_POP_RD;
                end
              end
              default: begin
                res_q   <= '0;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCHED_LINK: begin
          free_first_q <= rd_link;
          if (delay_q == 16'd0) begin
            state_q <= S_APP_SELF;
          end else begin
            prev_q  <= NIL;
            cur_q   <= wait_first_q;
            state_q <= S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          state_q <= (cur_q == NIL) ? S_INS_SELF : S_WALK_CMP;
        end
        S_WALK_CMP: begin
          // pass every entry due no later, so equal due ticks keep arrival order
          if (due_diff <= delay_q) begin
            prev_q  <= cur_q;
            cur_q   <= rd_link;
            state_q <= S_WALK_RD;
          end else begin
            state_q <= S_INS_SELF;
          end
        end
        S_INS_SELF: begin
          if (prev_q == NIL) begin
            wait_first_q <= n_q;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_INS_PREV;
          end
        end
        S_INS_PREV: state_q <= S_DONE;
        S_TICK_RD: begin
          if (wait_first_q == NIL) begin
            res_q.released <= rel_sat;
            state_q        <= S_DONE;
          end else begin
            n_q     <= wait_first_q;
            state_q <= S_TICK_CMP;
          end
        end
        S_TICK_CMP: begin
          if (rd_due == now_q) begin
            wait_first_q <= rd_link;
            cnt_q        <= cnt_q + PW'(1);
            state_q      <= S_APP_SELF;
          end else begin
            res_q.released <= rel_sat;
            state_q        <= S_DONE;
          end
        end
        S_APP_SELF: begin
          if (ready_first_q == NIL) begin
            ready_first_q <= n_q;
            ready_last_q  <= n_q;
            state_q       <= (op_q == ttq_pkg::OP_TICK) ? S_TICK_RD : S_DONE;
          end else begin
            state_q <= S_APP_TAIL;
          end
        end
        S_APP_TAIL: begin
          ready_last_q <= n_q;
          state_q      <= (op_q == ttq_pkg::OP_TICK) ? S_TICK_RD : S_DONE;
        end
        S_POP_RD: begin
          if (rd_link == NIL) begin
            ready_first_q <= NIL;
            ready_last_q  <= NIL;
          end else begin
            ready_first_q <= rd_link;
          end
          free_first_q <= n_q;
          res_q        <= {ttq_pkg::ST_POPPED, rd_task, rd_data, 4'd0};
          state_q      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_first_q == NIL) == (ready_last_q == NIL))
    else $error("ready FIFO head and tail disagree on empty");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result shown without finishing an item");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= NIL && free_first_q <= NIL && wait_first_q <= NIL)
    else $error("list pointer out of range");

  a_release_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK_CMP && rd_due == now_q) |=> cnt_q == $past(cnt_q) + PW'(1))
    else $error("release count not advanced");
`endif

endmodule
